[design/cbp_pkg.sv]
// shared types, codes and constants for the calibration blob parser
package cbp_pkg;

  localparam int unsigned COUNT_W = 40;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [15:0] GAIN_FRAC_BITS = 16'd10;
  localparam logic [COUNT_W:0] HDR_LEN = 41'd13;

  // section codes
  localparam logic [1:0] SEC_HEADER = 2'd0;
  localparam logic [1:0] SEC_GAIN_L = 2'd1;
  localparam logic [1:0] SEC_GAIN_R = 2'd2;
  localparam logic [1:0] SEC_MAP    = 2'd3;

  // final status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD          = 2'd1;
  localparam logic [1:0] ST_GAIN_SHORT   = 2'd2;
  localparam logic [1:0] ST_LEN_MISMATCH = 2'd3;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_GAINL,
    PH_GAINR,
    PH_HEAD2,
    PH_MAP,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic [1:0]  section;
    logic [31:0] element_index;
    logic [15:0] frac_bits;
    logic        is_final;
    logic [1:0]  status;
  } out_word_t;

  // running stream figures needed for the final status
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         byte_sum;
    logic               version_bad;
    logic [31:0]        gain_size;
    logic [31:0]        map_size;
  } stat_info_t;

endpackage

[design/calib_table_blob_parser_unit.sv]
// top level of the calibration blob parser: input stage, parser, output register
// a byte accepted is held in the input register, then its word or status is registered in the output register
// throughput: one byte per cycle while the output is not stalled, set by the single input and output register pair
// the output register takes a new word in the cycle the old one is taken
// reset: async active low, clears stream state and valids, expected_version to 1
// bytes that only fill the high half of a word or fall past the map give no output
module calib_table_blob_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbp_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import cbp_pkg::*;

  // configuration register
  logic [15:0] exp_ver_q;

  // input stage
  logic     s0_valid;
  in_word_t s0_word;
  logic     pop;

  // parser and status
  stat_info_t info;
  logic [1:0] status;
  logic       res_valid;
  out_word_t  res;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  // the held byte moves on when the output register is empty or being drained
  assign pop = s0_valid && (!out_valid_q || !out_stall_i);

  cbp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .pop_i      (pop),
    .s0_valid_o (s0_valid),
    .s0_word_o  (s0_word)
  );

  // checksum byte is the one being stepped
  cbp_status u_status (
    .info_i   (info),
    .check_i  (s0_word.data_byte),
    .status_o (status)
  );

  cbp_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (pop),
    .word_i             (s0_word),
    .expected_version_i (exp_ver_q),
    .status_i           (status),
    .info_o             (info),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= 16'd1;
    end else if (cfg_we_i) begin
      exp_ver_q <= cfg_wdata_i;
    end
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side can move");

  a_status_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_final |->
      out_word_o.word_value == 16'd0 && out_word_o.section == SEC_HEADER &&
      out_word_o.element_index == 32'd0 && out_word_o.frac_bits == 16'd0)
    else $error("status word carries payload");

  a_word_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_final |-> out_word_o.status == ST_OK)
    else $error("data word carries a status");

endmodule

[design/cbp_in_stage.sv]
// input register stage with stall toward the sender
module cbp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbp_pkg::in_word_t in_word_i,
  input  logic              pop_i,
  output logic              s0_valid_o,
  output cbp_pkg::in_word_t s0_word_o
);
  import cbp_pkg::*;

  logic     s0_valid_q, s0_valid_d;
  in_word_t s0_word_q;
  logic     take;

  // a held word leaves only on pop
  assign in_stall_o = s0_valid_q && !pop_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (take) begin
      s0_valid_d = 1'b1;
    end else if (pop_i) begin
      s0_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s0_word_q <= in_word_i;
    end
  end

  assign s0_valid_o = s0_valid_q;
  assign s0_word_o  = s0_word_q;

endmodule

[design/cbp_status.sv]
// final status evaluation from stream figures and the checksum byte
module cbp_status (
  input  cbp_pkg::stat_info_t info_i,
  input  logic [7:0]          check_i,
  output logic [1:0]          status_o
);
  import cbp_pkg::*;

  logic [COUNT_W:0] len;
  logic [COUNT_W:0] need;
  logic [COUNT_W:0] total;

  assign len   = {1'b0, info_i.byte_count} + 41'd1;
  assign need  = HDR_LEN + {7'b0, info_i.gain_size, 2'b00};
  assign total = need + {8'b0, info_i.map_size, 1'b0};

  always_comb begin
    if (len < 41'd3 || info_i.version_bad || check_i != info_i.byte_sum) begin
      status_o = ST_BAD;
    end else if (len < need) begin
      status_o = ST_GAIN_SHORT;
    end else if (len != total) begin
      status_o = ST_LEN_MISMATCH;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

[design/cbp_parser.sv]
// stream state, header walk and result build for one byte per step
module cbp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  cbp_pkg::in_word_t    word_i,
  input  logic [15:0]          expected_version_i,
  input  logic [1:0]           status_i,
  output cbp_pkg::stat_info_t  info_o,
  output logic                 res_valid_o,
  output cbp_pkg::out_word_t   res_o
);
  import cbp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         hold_q, hold_d;
  logic               vbad_q, vbad_d;
  logic [15:0]        gw_q, gw_d;
  logic [15:0]        mw_q, mw_d;
  logic [15:0]        fb_q, fb_d;
  logic [31:0]        gn_q, gn_d;
  logic [31:0]        mn_q, mn_d;
  logic [31:0]        sc_q, sc_d;
  logic [15:0]        word;
  logic               sc_done_g;
  logic               sc_done_m;

  assign word      = {hold_q, word_i.data_byte};
  assign sc_done_g = ({1'b0, sc_q} + 33'd1) >= {1'b0, gn_q};
  assign sc_done_m = ({1'b0, sc_q} + 33'd1) >= {1'b0, mn_q};

  assign info_o.byte_count  = cnt_q;
  assign info_o.byte_sum    = sum_q;
  assign info_o.version_bad = vbad_q;
  assign info_o.gain_size   = gn_q;
  assign info_o.map_size    = mn_q;

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    vbad_d  = vbad_q;
    gw_d    = gw_q;
    mw_d    = mw_q;
    fb_d    = fb_q;
    gn_d    = gn_q;
    mn_d    = mn_q;
    sc_d    = sc_q;
    if (step_i) begin
      if (word_i.is_last) begin
        // blob ends, back to a fresh stream
        phase_d = PH_HEAD1;
        cnt_d   = '0;
        sum_d   = '0;
        hold_d  = '0;
        vbad_d  = 1'b0;
        gw_d    = '0;
        mw_d    = '0;
        fb_d    = '0;
        gn_d    = '0;
        mn_d    = '0;
        sc_d    = '0;
      end else begin
        sum_d = sum_q + word_i.data_byte;
        if (cnt_q != COUNT_MAX) begin
          cnt_d = cnt_q + 40'd1;
        end
        if (!cnt_q[0]) begin
          hold_d = word_i.data_byte;
        end else begin
          case (phase_q)
            PH_HEAD1: begin
              if (cnt_q[2:1] == 2'd0) begin
                vbad_d = (word != expected_version_i);
              end else if (cnt_q[2:1] == 2'd1) begin
                gw_d = word;
              end else begin
                gn_d = {16'b0, gw_q} * {16'b0, word};
                sc_d = '0;
                phase_d = (gw_q != 16'd0 && word != 16'd0) ? PH_GAINL : PH_HEAD2;
              end
            end
            PH_GAINL, PH_GAINR: begin
              if (sc_done_g) begin
                sc_d = '0;
                phase_d = (phase_q == PH_GAINL) ? PH_GAINR : PH_HEAD2;
              end else begin
                sc_d = sc_q + 32'd1;
              end
            end
            PH_HEAD2: begin
              if (sc_q == 32'd0) begin
                fb_d = word;
                sc_d = 32'd1;
              end else if (sc_q == 32'd1) begin
                mw_d = word;
                sc_d = 32'd2;
              end else begin
                mn_d = {16'b0, mw_q} * {16'b0, word};
                sc_d = '0;
                phase_d = (mw_q != 16'd0 && word != 16'd0) ? PH_MAP : PH_TAIL;
              end
            end
            PH_MAP: begin
              if (sc_done_m) begin
                sc_d = '0;
                phase_d = PH_TAIL;
              end else begin
                sc_d = sc_q + 32'd1;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // result for this byte
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (word_i.is_last) begin
        res_valid_o    = 1'b1;
        res_o.is_final = 1'b1;
        res_o.status   = status_i;
      end else if (cnt_q[0]) begin
        case (phase_q)
          PH_HEAD1: begin
            res_valid_o         = 1'b1;
            res_o.word_value    = word;
            res_o.section       = SEC_HEADER;
            res_o.element_index = {30'b0, cnt_q[2:1]};
          end
          PH_GAINL, PH_GAINR: begin
            res_valid_o         = 1'b1;
            res_o.word_value    = word;
            res_o.section       = (phase_q == PH_GAINL) ? SEC_GAIN_L : SEC_GAIN_R;
            res_o.element_index = sc_q;
            res_o.frac_bits     = GAIN_FRAC_BITS;
          end
          PH_HEAD2: begin
            res_valid_o      = 1'b1;
            res_o.word_value = word;
            res_o.section    = SEC_HEADER;
            if (sc_q == 32'd0) begin
              res_o.element_index = 32'd3;
            end else if (sc_q == 32'd1) begin
              res_o.element_index = 32'd4;
            end else begin
              res_o.element_index = 32'd5;
            end
          end
          PH_MAP: begin
            res_valid_o         = 1'b1;
            res_o.word_value    = word;
            res_o.section       = SEC_MAP;
            res_o.element_index = sc_q;
            res_o.frac_bits     = fb_q;
          end
          default: begin
            res_valid_o = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      cnt_q   <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
      vbad_q  <= 1'b0;
      gw_q    <= '0;
      mw_q    <= '0;
      fb_q    <= '0;
      gn_q    <= '0;
      mn_q    <= '0;
      sc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
      vbad_q  <= vbad_d;
      gw_q    <= gw_d;
      mw_q    <= mw_d;
      fb_q    <= fb_d;
      gn_q    <= gn_d;
      mn_q    <= mn_d;
      sc_q    <= sc_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.is_last |=> cnt_q == '0 && phase_q == PH_HEAD1 && sc_q == '0)
    else $error("stream state not cleared after last byte");

  a_gain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAINL || phase_q == PH_GAINR) |-> gn_q != 32'd0)
    else $error("gain section entered with empty table");

  a_map_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MAP |-> mn_q != 32'd0)
    else $error("map section entered with empty table");

endmodule
